@@ rtl/core/fugm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fugm_pkg: shared types and constants for the unicode glyph map
// Transaction payloads, table entry layout, word codes and scan states.
// ----------------------------------------------------------------------------
package fugm_pkg;

   // operation codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // configuration register indexes
   localparam logic CSR_GLYPH_COUNT_MODE   = 1'b0;
   localparam logic CSR_GLYPH_HEIGHT_BYTES = 1'b1;

   localparam logic [7:0] GLYPH_HEIGHT_RESET = 8'd16;

   // unicode table control words
   localparam logic [15:0] WORD_SEPARATOR = 16'hFFFF;
   localparam logic [15:0] WORD_SEQUENCE  = 16'hFFFE;

   localparam logic [16:0] FONT_HEADER_BYTES = 17'd4;
   localparam logic [10:0] GLYPHS_SMALL      = 11'd256;
   localparam logic [10:0] GLYPHS_LARGE      = 11'd512;

   typedef struct packed {
      logic        operation;
      logic [15:0] word;
   } req_type;

   typedef struct packed {
      logic [8:0]  glyph_index;
      logic [16:0] glyph_offset;
      logic        undefined;
   } rsp_type;

   typedef struct packed {
      logic [15:0] code;
      logic [8:0]  glyph;
   } entry_type;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_RUN,
      SCAN_MULT,
      SCAN_RESP
   } scan_state_type;

endpackage
`default_nettype wire

@@ rtl/core/fugm_table_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fugm_table_ram: entry memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fugm_table_ram #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire fugm_pkg::entry_type wr_data,
   input  wire logic                rd_en,
   input  wire logic [AW-1:0]       rd_addr,
   output fugm_pkg::entry_type      rd_data
);
   import fugm_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/fugm_loader.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fugm_loader: unicode table walker
// Tracks glyph counter, sequence skip and fill count; writes entries in order.
// ----------------------------------------------------------------------------
module fugm_loader #(
   parameter int DEPTH = 512,
   parameter int AW    = 9,
   parameter int CW    = 10
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load_en,
   input  wire logic [15:0]         load_word,
   input  wire logic                glyph_count_mode,
   output logic                     wr_en,
   output logic [AW-1:0]            wr_addr,
   output fugm_pkg::entry_type      wr_data,
   output logic [CW-1:0]            fill_count
);
   import fugm_pkg::*;

   logic [CW-1:0] fill_ff, fill_in;
   logic [9:0]    glyph_ff, glyph_in;
   logic          skip_ff, skip_in;
   logic          done_ff, done_in;
   logic [10:0]   glyph_next;
   logic [10:0]   glyph_limit;
   logic [CW-1:0] fill_next;

   assign glyph_next  = {1'b0, glyph_ff} + 11'd1;
   assign glyph_limit = glyph_count_mode ? GLYPHS_LARGE : GLYPHS_SMALL;
   assign fill_next   = fill_ff + CW'(1);

   always_comb begin
      fill_in  = fill_ff;
      glyph_in = glyph_ff;
      skip_in  = skip_ff;
      done_in  = done_ff;
      wr_en    = 1'b0;
      if (load_en && !done_ff) begin
         if (load_word == WORD_SEPARATOR) begin
            glyph_in = glyph_next[9:0];
            skip_in  = 1'b0;
            if (glyph_next >= glyph_limit) begin
               done_in = 1'b1;
            end
         end else if (load_word == WORD_SEQUENCE) begin
            skip_in = 1'b1;
         end else if (!skip_ff && fill_ff < CW'(DEPTH)) begin
            wr_en   = 1'b1;
            fill_in = fill_next;
            if (fill_next >= CW'(DEPTH)) begin
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         glyph_ff <= '0;
         skip_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         glyph_ff <= glyph_in;
         skip_ff  <= skip_in;
         done_ff  <= done_in;
      end
   end

   assign wr_addr       = fill_ff[AW-1:0];
   assign wr_data.code  = load_word;
   assign wr_data.glyph = glyph_ff[8:0];
   assign fill_count    = fill_ff;

endmodule
`default_nettype wire

@@ rtl/core/fugm_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fugm_scan: lookup sequencer
// Streams entries out of the table one per cycle, stops at the first match,
// then forms the byte offset and presents the result for one cycle.
// ----------------------------------------------------------------------------
module fugm_scan #(
   parameter int AW = 9,
   parameter int CW = 10
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                lookup_en,
   input  wire logic [15:0]         lookup_code,
   input  wire logic [CW-1:0]       fill_count,
   input  wire logic [7:0]          glyph_height,
   output logic                     rd_en,
   output logic [AW-1:0]            rd_addr,
   input  wire fugm_pkg::entry_type rd_data,
   output logic                     busy,
   output logic                     rsp_strobe,
   output fugm_pkg::rsp_type        rsp_item
);
   import fugm_pkg::*;

   scan_state_type state_ff, state_in;
   logic [CW-1:0]  ptr_ff, ptr_in;
   logic           chk_valid_ff, chk_valid_in;
   logic           chk_last_ff, chk_last_in;
   logic [15:0]    code_ff, code_in;
   logic [8:0]     glyph_ff, glyph_in;
   logic           hit_ff, hit_in;
   logic [16:0]    offset_ff, offset_in;
   logic           match;
   logic [CW-1:0]  ptr_next;

   assign match    = chk_valid_ff && (rd_data.code == code_ff);
   assign ptr_next = ptr_ff + CW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SCAN_IDLE: begin
            if (lookup_en) begin
               state_in = SCAN_RUN;
            end
         end
         SCAN_RUN: begin
            if (match) begin
               state_in = SCAN_MULT;
            end else if ((chk_valid_ff && chk_last_ff) || fill_count == '0) begin
               state_in = SCAN_RESP;
            end
         end
         SCAN_MULT: state_in = SCAN_RESP;
         SCAN_RESP: state_in = SCAN_IDLE;
         default:   state_in = SCAN_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      ptr_in       = ptr_ff;
      chk_valid_in = 1'b0;
      chk_last_in  = chk_last_ff;
      code_in      = code_ff;
      glyph_in     = glyph_ff;
      hit_in       = hit_ff;
      offset_in    = offset_ff;
      rd_en        = 1'b0;
      busy         = 1'b1;
      rsp_strobe   = 1'b0;
      unique case (state_ff)
         SCAN_IDLE: begin
            busy   = 1'b0;
            ptr_in = '0;
            hit_in = 1'b0;
            if (lookup_en) begin
               code_in = lookup_code;
            end
         end
         SCAN_RUN: begin
            rd_en        = (ptr_ff < fill_count) && !match;
            chk_valid_in = rd_en;
            chk_last_in  = (ptr_next == fill_count);
            if (rd_en) begin
               ptr_in = ptr_next;
            end
            if (match) begin
               glyph_in = rd_data.glyph;
               hit_in   = 1'b1;
            end
         end
         SCAN_MULT: begin
            offset_in = FONT_HEADER_BYTES + ({8'd0, glyph_ff} * {9'd0, glyph_height});
         end
         SCAN_RESP: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SCAN_IDLE;
         chk_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= chk_valid_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      chk_last_ff <= chk_last_in;
      code_ff     <= code_in;
      glyph_ff    <= glyph_in;
      offset_ff   <= offset_in;
   end

   assign rd_addr               = ptr_ff[AW-1:0];
   assign rsp_item.glyph_index  = hit_ff ? glyph_ff : 9'd0;
   assign rsp_item.glyph_offset = hit_ff ? offset_ff : 17'd0;
   assign rsp_item.undefined    = !hit_ff;

endmodule
`default_nettype wire

@@ rtl/core/font_unicode_glyph_map_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// font_unicode_glyph_map_unit: PSF1 unicode table glyph lookup
// Builds a code point to glyph map from table words and answers lookups.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: a transaction is taken when start is high and busy low.
//   req_item.operation selects a table load word or a code point lookup.
//   Load words give no response; busy stays low.
//   A lookup raises busy and walks the stored entries in load order, one
//   entry read from the table memory per cycle (one read port). A hit
//   passes through the offset step before rsp_strobe; a miss, or an empty
//   table, strobes rsp_strobe once the walk ends; busy drops in the cycle
//   after the strobe. The walk over the table memory sets the lookup time.
//   Response: rsp_item is valid for the single cycle rsp_strobe is high;
//   the receiver has no way to stall it.
//   CSR channel: csr_ready is always high. Index 0 is glyph_count_mode
//   (256 or 512 glyphs), index 1 is glyph_height_bytes. Write only while idle.
//   Reset clears the fill count, glyph counter and scan control; the entry
//   memory is not cleared, since entries at or beyond the fill count are
//   never read. Height resets to 16, glyph count mode to 256 glyphs.
// ----------------------------------------------------------------------------
module font_unicode_glyph_map_unit #(
   parameter int TABLE_ENTRIES = 512
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              start,
   output logic                   busy,
   input  wire fugm_pkg::req_type req_item,
   // response channel
   output logic                   rsp_strobe,
   output fugm_pkg::rsp_type      rsp_item,
   // configuration channel
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_index,
   input  wire logic [7:0]        csr_wdata
);
   import fugm_pkg::*;

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   // configuration registers
   logic       mode_ff, mode_in;
   logic [7:0] height_ff, height_in;

   // request decode
   logic req_accept;
   logic load_en;
   logic lookup_en;

   // table memory ports
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;
   logic [CW-1:0] fill_count;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in   = mode_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GLYPH_COUNT_MODE:   mode_in   = csr_wdata[0];
            CSR_GLYPH_HEIGHT_BYTES: height_in = csr_wdata;
            default:                mode_in   = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         height_ff <= GLYPH_HEIGHT_RESET;
      end else begin
         mode_ff   <= mode_in;
         height_ff <= height_in;
      end
   end

   // loads do not raise busy; lookups hold busy until the response
   assign req_accept = start && !busy;
   assign load_en    = req_accept && (req_item.operation == OP_LOAD);
   assign lookup_en  = req_accept && (req_item.operation == OP_LOOKUP);

   fugm_loader #(
      .DEPTH (TABLE_ENTRIES),
      .AW    (AW),
      .CW    (CW)
   ) u_loader (
      .clock            (clock),
      .reset            (reset),
      .load_en          (load_en),
      .load_word        (req_item.word),
      .glyph_count_mode (mode_ff),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .fill_count       (fill_count)
   );

   // writes and scan reads never overlap: loads are refused while busy
   fugm_table_ram #(
      .DEPTH (TABLE_ENTRIES),
      .AW    (AW)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fugm_scan #(
      .AW (AW),
      .CW (CW)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .lookup_en    (lookup_en),
      .lookup_code  (req_item.word),
      .fill_count   (fill_count),
      .glyph_height (height_ff),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .busy         (busy),
      .rsp_strobe   (rsp_strobe),
      .rsp_item     (rsp_item)
   );

endmodule
`default_nettype wire

@@ tb/font_unicode_glyph_map_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// font_unicode_glyph_map_unit_tb: self-checking bench for the glyph map
// Drives unicode table load words and code point lookups against an internal
// model of the map, and checks every lookup response field by field.
// ----------------------------------------------------------------------------
module font_unicode_glyph_map_unit_tb;
   import fugm_pkg::*;

   localparam int TABLE_ENTRIES     = 512;
   localparam int CLOCK_HALF        = 6;
   localparam int RESET_CYCLES      = 9;
   // a load word can still be in the pipe after the last response
   localparam int SETTLE_CYCLES     = 4;
   // longest lookup walks all TABLE_ENTRIES entries; margin on top
   localparam int DRAIN_CYCLES      = TABLE_ENTRIES + 8;
   // cycles with no transaction at all before the run is declared hung
   localparam int STALL_LIMIT       = 3000;
   localparam int MAX_GAP           = 13;
   localparam int FILL_CHUNK_ITEMS  = 100;
   localparam int AFTER_FILL_LOOKUPS = 100;
   // the 256-glyph mode would close the table at glyph 256; move to 512
   // glyphs well before that so the fill runs on into glyph indexes >= 256
   localparam int MODE_SWITCH_GLYPH = 200;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_index;
   logic [7:0] csr_wdata;

   font_unicode_glyph_map_unit #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Glyph map model: table contents, load walk state and register copies.
   // Entries past map_fill are never looked at, which stands in for the
   // per-entry valid bits.
   // ------------------------------------------------------------------------
   logic [15:0] map_code  [TABLE_ENTRIES];
   logic [8:0]  map_glyph [TABLE_ENTRIES];
   int          map_fill;
   int          map_glyph_ctr;
   logic        map_skip;      // inside a sequence part, drop words
   logic        map_closed;    // table full or all glyphs walked
   logic        cfg_mode;
   logic [7:0]  cfg_height;

   rsp_type     expected_lookups[$];
   rsp_type     lookup_want;
   int          mismatch_count;
   int          stall_cycles;
   int          items_sent;
   int          next_gap;
   int          no_idle_left;  // items left in a back-to-back stretch
   logic        req_held;      // start left high for a back-to-back item

   // one table word into the map
   function automatic void glyph_map_load(input logic [15:0] word);
      if (map_closed)
         return;
      if (word == WORD_SEPARATOR) begin
         map_glyph_ctr++;
         map_skip = 1'b0;
         // glyph count taken from the mode register as it is right now
         if (map_glyph_ctr >= (cfg_mode ? int'(GLYPHS_LARGE) : int'(GLYPHS_SMALL)))
            map_closed = 1'b1;
         return;
      end
      if (word == WORD_SEQUENCE) begin
         map_skip = 1'b1;
         return;
      end
      if (map_skip)
         return;
      if (map_fill < TABLE_ENTRIES) begin
         map_code[map_fill]  = word;
         map_glyph[map_fill] = map_glyph_ctr[8:0];
         map_fill++;
      end
      if (map_fill >= TABLE_ENTRIES)
         map_closed = 1'b1;
   endfunction

   // first stored entry with this code wins; a miss flags undefined
   function automatic rsp_type glyph_map_lookup(input logic [15:0] code);
      rsp_type r;
      r.glyph_index  = '0;
      r.glyph_offset = '0;
      r.undefined    = 1'b1;
      for (int i = 0; i < map_fill; i++) begin
         if (map_code[i] == code) begin
            r.glyph_index  = map_glyph[i];
            r.glyph_offset = FONT_HEADER_BYTES + map_glyph[i] * cfg_height;
            r.undefined    = 1'b0;
            return r;
         end
      end
      return r;
   endfunction

   // table words: printable range for duplicates, otherwise anything
   function automatic logic [15:0] pick_table_code();
      case ($urandom_range(0, 3))
         0:       return 16'h0020 + 16'($urandom_range(0, 95));
         3:       return 16'($urandom);
         default: return 16'($urandom_range(0, 16'hFFFD));
      endcase
   endfunction

   // lookups: half of them aim at codes already stored
   function automatic logic [15:0] pick_lookup_code();
      case ($urandom_range(0, 3))
         0, 1:    return (map_fill > 0) ? map_code[$urandom_range(0, map_fill - 1)]
                                        : 16'($urandom);
         2:       return 16'h0020 + 16'($urandom_range(0, 95));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_height(input int phase);
      case (phase % 5)
         0:       return 8'd1;
         1:       return 8'd255;
         2:       return 8'd0;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Request driver. Inputs move on the falling edge; the transaction is
   // taken at the first rising edge with busy low. The gap before the next
   // item is drawn right after acceptance so start is only lowered when an
   // idle cycle really follows.
   // ------------------------------------------------------------------------
   task automatic send_item(input logic op, input logic [15:0] word);
      req_type item;
      item.operation = op;
      item.word      = word;
      repeat (next_gap) @(negedge clock);
      start    <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      // accepted at this edge; registers are stable, so predict now
      if (op == OP_LOOKUP)
         expected_lookups.push_back(glyph_map_lookup(word));
      else
         glyph_map_load(word);
      items_sent++;
      @(negedge clock);
      if (no_idle_left > 0) begin
         no_idle_left--;
         next_gap = 0;
      end else begin
         next_gap = $urandom_range(0, MAX_GAP);
         if ($urandom_range(0, 15) == 0)
            no_idle_left = $urandom_range(10, 40);
      end
      req_held = (next_gap == 0);
      if (!req_held)
         start <= 1'b0;
   endtask

   task automatic drop_request();
      if (req_held) begin
         start    <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   // register write, only once every lookup has answered and loads settled
   task automatic write_csr(input logic idx, input logic [7:0] data);
      drop_request();
      while (expected_lookups.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      if (idx == CSR_GLYPH_COUNT_MODE)
         cfg_mode = data[0];
      else
         cfg_height = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // nothing stored yet: every lookup misses, markers included
   task automatic test_empty_table();
      send_item(OP_LOOKUP, 16'h0000);
      send_item(OP_LOOKUP, WORD_SEPARATOR);
      send_item(OP_LOOKUP, WORD_SEQUENCE);
   endtask

   // small hand-built table: sequence skip, duplicate code, extreme heights
   task automatic test_directed_table();
      write_csr(CSR_GLYPH_COUNT_MODE, 8'd0);
      write_csr(CSR_GLYPH_HEIGHT_BYTES, 8'd255);
      // glyph 0
      send_item(OP_LOAD, 16'h0041);
      send_item(OP_LOAD, 16'h0000);
      send_item(OP_LOAD, WORD_SEPARATOR);
      // glyph 1: one code, then a sequence part that must be dropped
      send_item(OP_LOAD, 16'h0042);
      send_item(OP_LOAD, WORD_SEQUENCE);
      send_item(OP_LOAD, 16'h1234);
      send_item(OP_LOAD, WORD_SEQUENCE);
      send_item(OP_LOAD, 16'hFFFD);
      send_item(OP_LOAD, WORD_SEPARATOR);
      // glyph 2: repeats 0x0041, which must still resolve to glyph 0
      send_item(OP_LOAD, 16'h0041);
      send_item(OP_LOAD, 16'hFFFD);
      send_item(OP_LOAD, WORD_SEPARATOR);
      send_item(OP_LOOKUP, 16'h0041);
      send_item(OP_LOOKUP, 16'h0042);
      send_item(OP_LOOKUP, 16'h1234);
      send_item(OP_LOOKUP, 16'hFFFD);
      send_item(OP_LOOKUP, 16'h0000);
      send_item(OP_LOOKUP, WORD_SEPARATOR);
      // zero height: every hit sits right after the font header
      write_csr(CSR_GLYPH_HEIGHT_BYTES, 8'd0);
      send_item(OP_LOOKUP, 16'h0042);
      write_csr(CSR_GLYPH_HEIGHT_BYTES, 8'd1);
      send_item(OP_LOOKUP, 16'hFFFD);
   endtask

   // well-formed glyph lists with random content, lookups mixed in, until
   // the table closes; now and then a sequence part or a lost separator
   task automatic test_random_fill();
      int phase;
      int chunk_start;
      phase = 0;
      while (!map_closed) begin
         if (!cfg_mode && map_glyph_ctr >= MODE_SWITCH_GLYPH)
            write_csr(CSR_GLYPH_COUNT_MODE, 8'd1);
         write_csr(CSR_GLYPH_HEIGHT_BYTES, pick_height(phase));
         phase++;
         chunk_start = items_sent;
         while (!map_closed && items_sent - chunk_start < FILL_CHUNK_ITEMS &&
                !(!cfg_mode && map_glyph_ctr >= MODE_SWITCH_GLYPH)) begin
            repeat ($urandom_range(0, 3)) begin
               if ($urandom_range(0, 3) == 0)
                  send_item(OP_LOOKUP, pick_lookup_code());
               send_item(OP_LOAD, pick_table_code());
            end
            if ($urandom_range(0, 5) == 0) begin
               send_item(OP_LOAD, WORD_SEQUENCE);
               repeat ($urandom_range(0, 3))
                  send_item(OP_LOAD, pick_table_code());
            end
            // a missing separator merges two lists
            if ($urandom_range(0, 19) != 0)
               send_item(OP_LOAD, WORD_SEPARATOR);
         end
      end
   endtask

   // table closed: lookups over the full map, stray loads must change nothing
   task automatic test_after_fill();
      int lookups_left;
      write_csr(CSR_GLYPH_COUNT_MODE, 8'd0);
      write_csr(CSR_GLYPH_HEIGHT_BYTES, 8'd255);
      lookups_left = AFTER_FILL_LOOKUPS;
      while (lookups_left > 0) begin
         if (lookups_left == AFTER_FILL_LOOKUPS / 2)
            write_csr(CSR_GLYPH_HEIGHT_BYTES, 8'($urandom_range(1, 254)));
         if ($urandom_range(0, 5) == 0) begin
            send_item(OP_LOAD, ($urandom_range(0, 1) != 0) ? WORD_SEPARATOR
                                                          : pick_table_code());
         end else begin
            send_item(OP_LOOKUP, pick_lookup_code());
            lookups_left--;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Clock, reset and test sequence
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_item       = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_GLYPH_COUNT_MODE;
      csr_wdata      = '0;
      map_fill       = 0;
      map_glyph_ctr  = 0;
      map_skip       = 1'b0;
      map_closed     = 1'b0;
      cfg_mode       = 1'b0;
      cfg_height     = GLYPH_HEIGHT_RESET;
      mismatch_count = 0;
      items_sent     = 0;
      next_gap       = 0;
      no_idle_left   = 0;
      req_held       = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_table();
      test_directed_table();
      test_random_fill();
      test_after_fill();

      // let the last lookups answer, then watch for any stray response
      drop_request();
      while (expected_lookups.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response checker: each strobe is matched against the oldest lookup
   // still waiting. Sampled on the rising edge, before the block updates.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_lookups.size() == 0) begin
            report_mismatch("response with no lookup waiting", rsp_item.glyph_index, 0);
         end else begin
            lookup_want = expected_lookups.pop_front();
            if (rsp_item.glyph_index !== lookup_want.glyph_index)
               report_mismatch("glyph_index", rsp_item.glyph_index,
                               lookup_want.glyph_index);
            if (rsp_item.glyph_offset !== lookup_want.glyph_offset)
               report_mismatch("glyph_offset", rsp_item.glyph_offset,
                               lookup_want.glyph_offset);
            if (rsp_item.undefined !== lookup_want.undefined)
               report_mismatch("undefined", rsp_item.undefined, lookup_want.undefined);
         end
      end
   end

   // watchdog: any request, response or register transaction restarts it
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
